// ===== src/bcc_pkg.sv =====
// ============================================================================
// bcc_pkg
// Shared constants, types and helpers for the byte coded CPU core.
// ============================================================================
`default_nettype none

package bcc_pkg;

    localparam int MEM_BYTES = 256;
    localparam int REG_COUNT = 4;
    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int STORE_TOP = 128;
    localparam logic [7:0] LIMIT_RESET = 8'd192;
    localparam logic [7:0] SP_RESET = 8'd255;

    localparam logic [7:0] OP_MOVE = 8'd1;
    localparam logic [7:0] OP_ADD = 8'd2;
    localparam logic [7:0] OP_SUB = 8'd3;
    localparam logic [7:0] OP_LOAD = 8'd4;
    localparam logic [7:0] OP_STORE = 8'd5;
    localparam logic [7:0] OP_JUMP = 8'd6;
    localparam logic [7:0] OP_CMP = 8'd7;
    localparam logic [7:0] OP_HALT = 8'd8;
    localparam logic [7:0] OP_PUSH = 8'd9;
    localparam logic [7:0] OP_POP = 8'd10;
    localparam logic [7:0] OP_JZ = 8'd11;
    localparam logic [7:0] OP_JNZ = 8'd12;
    localparam logic [7:0] OP_JL = 8'd13;
    localparam logic [7:0] OP_JG = 8'd14;
    localparam logic [7:0] OP_JB = 8'd15;
    localparam logic [7:0] OP_JAE = 8'd16;
    localparam logic [7:0] OP_CALL = 8'd17;
    localparam logic [7:0] OP_RET = 8'd18;

    typedef enum logic [1:0] {
        ACT_WRITE,
        ACT_READ,
        ACT_EXEC,
        ACT_START
    } action_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HWR,
        S_HRD0,
        S_HRD1,
        S_CHECK,
        S_F0,
        S_F1,
        S_F2,
        S_F3,
        S_DEC,
        S_WRD,
        S_WWR,
        S_COMMIT,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        K_HALT,
        K_SIMPLE,
        K_RD,
        K_WR
    } kind_t;

    typedef enum logic [1:0] {
        A_HOST,
        A_PC,
        A_WORD
    } addr_sel_t;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_OP,
        CAP_X,
        CAP_Y,
        CAP_WORD,
        CAP_READ
    } cap_t;

    typedef struct packed {
        logic      latch;
        addr_sel_t addr_sel;
        logic [1:0] offset;
        logic      mem_we;
        logic      wsrc_word;
        cap_t      cap;
        logic      set_run;
        logic      halt;
        logic      commit;
    } cmd_t;

    typedef struct packed {
        logic  running;
        logic  pc_ok;
        kind_t kind;
    } sts_t;

    function automatic logic [3:0] make_flags(input logic [31:0] r, input logic c,
                                              input logic v);
        make_flags = {v, c, r[31], (r == 32'd0)};
    endfunction

    function automatic logic is_pos(input logic [31:0] x);
        is_pos = (x != 32'd0) && !x[31];
    endfunction

endpackage

`default_nettype wire

// ===== src/bcc_ram.sv =====
// ============================================================================
// bcc_ram
// Generic single port RAM with registered read data.
// ============================================================================
`default_nettype none

module bcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/bcc_ctrl.sv =====
// ============================================================================
// bcc_ctrl
// Sequencer: host actions, instruction fetch, word transfers and commit.
// ============================================================================
`default_nettype none

module bcc_ctrl import bcc_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] action,
    input  wire sts_t       sts,
    output cmd_t            cmd,
    output logic            busy,
    output logic            done
);

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.addr_sel = A_HOST;
        cmd.cap      = CAP_NONE;
        cmd.offset   = cnt_reg[1:0];
        busy         = 1'b1;
        done         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch = 1'b1;
                    case (action_t'(action))
                        ACT_WRITE: state_next = S_HWR;
                        ACT_READ:  state_next = S_HRD0;
                        ACT_EXEC:  state_next = S_CHECK;
                        default:
                        begin
                            cmd.set_run = 1'b1;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_HWR:
            begin
                cmd.mem_we = 1'b1;
                state_next = S_DONE;
            end
            S_HRD0: state_next = S_HRD1;
            S_HRD1:
            begin
                cmd.cap    = CAP_READ;
                state_next = S_DONE;
            end
            S_CHECK:
            begin
                if (!sts.running)
                begin
                    state_next = S_DONE;
                end
                else if (!sts.pc_ok)
                begin
                    cmd.halt   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_F0;
                end
            end
            S_F0:
            begin
                cmd.addr_sel = A_PC;
                cmd.offset   = 2'd0;
                state_next   = S_F1;
            end
            S_F1:
            begin
                cmd.addr_sel = A_PC;
                cmd.offset   = 2'd1;
                cmd.cap      = CAP_OP;
                state_next   = S_F2;
            end
            S_F2:
            begin
                cmd.addr_sel = A_PC;
                cmd.offset   = 2'd2;
                cmd.cap      = CAP_X;
                state_next   = S_F3;
            end
            S_F3:
            begin
                cmd.cap    = CAP_Y;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                cnt_next = 3'd0;
                case (sts.kind)
                    K_HALT:
                    begin
                        cmd.halt   = 1'b1;
                        state_next = S_DONE;
                    end
                    K_SIMPLE:
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_DONE;
                    end
                    K_RD:    state_next = S_WRD;
                    default: state_next = S_WWR;
                endcase
            end
            S_WRD:
            begin
                // Byte n is addressed in one cycle and shifted in the next.
                cmd.addr_sel = A_WORD;
                if (cnt_reg != 3'd0)
                begin
                    cmd.cap = CAP_WORD;
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_WWR:
            begin
                cmd.addr_sel  = A_WORD;
                cmd.mem_we    = 1'b1;
                cmd.wsrc_word = 1'b1;
                cnt_next      = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/bcc_dp.sv =====
// ============================================================================
// bcc_dp
// Datapath: architectural state, byte memory, decode checks and execute.
// ============================================================================
`default_nettype none

module bcc_dp import bcc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    input  wire logic [7:0]  address,
    input  wire logic [7:0]  data,
    input  wire logic        cfg_valid,
    input  wire logic [7:0]  cfg_data,
    output sts_t             sts,
    output logic             running,
    output logic [7:0]       pc,
    output logic [7:0]       sp,
    output logic [3:0]       flags,
    output logic [7:0]       read_data,
    output logic [31:0]      reg0,
    output logic [31:0]      reg1,
    output logic [31:0]      reg2,
    output logic [31:0]      reg3
);

    logic [7:0]  lim_reg, pc_reg, pc_next, sp_reg, sp_next;
    logic [3:0]  flags_reg, flags_next;
    logic        run_reg, run_next;
    logic [31:0] rf_reg [REG_COUNT];
    logic [31:0] rf_next [REG_COUNT];
    logic [7:0]  haddr_reg, hdata_reg, rdbyte_reg;
    logic [7:0]  op_reg, x_reg, y_reg;
    logic [31:0] word_reg;

    logic [9:0]  limw, pcw, spw, xw, yw;
    logic        xv, yv;
    logic [31:0] a, b, sum, diff, word_src;
    logic        add_v, sub_v, take;
    logic [7:0]  base, mem_addr, mem_wdata, mem_rdata;
    logic [31:0] shifted;
    kind_t       kind;

    assign limw = {2'b00, lim_reg};
    assign pcw  = {2'b00, pc_reg};
    assign spw  = {2'b00, sp_reg};
    assign xw   = {2'b00, x_reg};
    assign yw   = {2'b00, y_reg};
    assign xv   = x_reg < 8'(REG_COUNT);
    assign yv   = y_reg < 8'(REG_COUNT);

    assign a    = rf_reg[x_reg[REG_IDX_W-1:0]];
    assign b    = rf_reg[y_reg[REG_IDX_W-1:0]];
    assign sum  = a + b;
    assign diff = a - b;
    assign add_v = (is_pos(a) && is_pos(b) && sum[31]) ||
                   (a[31] && b[31] && is_pos(sum));
    assign sub_v = (is_pos(a) && b[31] && diff[31]) ||
                   (a[31] && is_pos(b) && is_pos(diff));

    // Decode: legality checks, word transfer base and store source.
    always_comb
    begin
        kind     = K_HALT;
        base     = y_reg;
        word_src = a;
        case (op_reg)
            OP_MOVE:
            begin
                base = pc_reg + 8'd2;
                if (pcw + 10'd5 < limw && xv) kind = K_RD;
            end
            OP_ADD, OP_SUB:
            begin
                if (pcw + 10'd2 < limw && xv && yv) kind = K_SIMPLE;
            end
            OP_CMP:
            begin
                if (pcw + 10'd1 < limw && xv && yv) kind = K_SIMPLE;
            end
            OP_LOAD:
            begin
                if (pcw + 10'd2 < limw && xv && yw + 10'd3 < limw) kind = K_RD;
            end
            OP_STORE:
            begin
                if (pcw + 10'd2 < limw && xv && yw + 10'd3 < limw &&
                    yw + 10'd3 < 10'(STORE_TOP)) kind = K_WR;
            end
            OP_JUMP:
            begin
                if (pcw + 10'd4 < limw) kind = K_SIMPLE;
            end
            OP_PUSH:
            begin
                base = sp_reg - 8'd3;
                if (pcw + 10'd1 < limw && xv && spw >= limw + 10'd3) kind = K_WR;
            end
            OP_POP:
            begin
                base = sp_reg + 8'd1;
                if (pcw + 10'd1 < limw && xv && spw + 10'd1 >= limw &&
                    spw + 10'd4 < 10'(MEM_BYTES)) kind = K_RD;
            end
            OP_JZ, OP_JNZ, OP_JG, OP_JB, OP_JAE:
            begin
                if (pcw + 10'd1 < limw && xw < limw) kind = K_SIMPLE;
            end
            OP_JL:
            begin
                if (pcw + 10'd1 < limw) kind = K_SIMPLE;
            end
            OP_CALL:
            begin
                base     = sp_reg - 8'd3;
                word_src = {22'd0, pcw + 10'd2};
                if (spw >= limw + 10'd3) kind = K_WR;
            end
            OP_RET:
            begin
                base = sp_reg + 8'd1;
                if (pcw + 10'd2 < limw && xw < limw && spw >= limw &&
                    spw + 10'd4 < 10'(MEM_BYTES)) kind = K_RD;
            end
            default: kind = K_HALT;
        endcase
    end

    assign sts.running = run_reg;
    assign sts.pc_ok   = pc_reg < lim_reg;
    assign sts.kind    = kind;

    always_comb
    begin
        case (cmd.addr_sel)
            A_PC:    mem_addr = pc_reg + {6'd0, cmd.offset};
            A_WORD:  mem_addr = base + {6'd0, cmd.offset};
            default: mem_addr = haddr_reg;
        endcase
    end

    assign shifted   = word_src >> {cmd.offset, 3'b000};
    assign mem_wdata = cmd.wsrc_word ? shifted[7:0] : hdata_reg;

    bcc_ram #(
        .WIDTH(8),
        .DEPTH(MEM_BYTES)
    ) u_mem (
        .clk  (clk),
        .we   (cmd.mem_we),
        .addr (mem_addr[ADDR_W-1:0]),
        .wdata(mem_wdata),
        .rdata(mem_rdata)
    );

    always_comb
    begin
        case (op_reg)
            OP_JZ:   take = flags_reg[0];
            OP_JNZ:  take = !flags_reg[0];
            OP_JL:   take = flags_reg[1] != flags_reg[3];
            OP_JG:   take = (flags_reg[1] == flags_reg[3]) && !flags_reg[0];
            OP_JB:   take = flags_reg[2];
            default: take = !flags_reg[2];
        endcase
    end

    // Architectural update: start and halt of the run flag, and results at commit.
    always_comb
    begin
        pc_next    = pc_reg;
        sp_next    = sp_reg;
        flags_next = flags_reg;
        run_next   = run_reg;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            rf_next[i] = rf_reg[i];
        end
        if (cmd.set_run)
        begin
            run_next = 1'b1;
        end
        if (cmd.halt)
        begin
            run_next = 1'b0;
        end
        if (cmd.commit)
        begin
            case (op_reg)
                OP_MOVE:
                begin
                    rf_next[x_reg[REG_IDX_W-1:0]] = word_reg;
                    pc_next = pc_reg + 8'd6;
                end
                OP_ADD:
                begin
                    rf_next[x_reg[REG_IDX_W-1:0]] = sum;
                    flags_next = make_flags(sum, sum < a, add_v);
                    pc_next = pc_reg + 8'd3;
                end
                OP_SUB, OP_CMP:
                begin
                    if (op_reg == OP_SUB)
                    begin
                        rf_next[x_reg[REG_IDX_W-1:0]] = diff;
                    end
                    flags_next = make_flags(diff, a < b, sub_v);
                    pc_next = pc_reg + 8'd3;
                end
                OP_LOAD:
                begin
                    rf_next[x_reg[REG_IDX_W-1:0]] = word_reg;
                    pc_next = pc_reg + 8'd3;
                end
                OP_STORE: pc_next = pc_reg + 8'd3;
                OP_JUMP:  pc_next = x_reg;
                OP_PUSH:
                begin
                    sp_next = sp_reg - 8'd4;
                    pc_next = pc_reg + 8'd2;
                end
                OP_POP:
                begin
                    rf_next[x_reg[REG_IDX_W-1:0]] = word_reg;
                    sp_next = sp_reg + 8'd4;
                    pc_next = pc_reg + 8'd2;
                end
                OP_CALL:
                begin
                    sp_next = sp_reg - 8'd4;
                    pc_next = x_reg;
                end
                OP_RET:
                begin
                    // A return address that does not fit the PC halts the core.
                    if (word_reg[31:8] == 24'd0)
                    begin
                        pc_next = word_reg[7:0];
                        sp_next = sp_reg + 8'd4;
                    end
                    else
                    begin
                        run_next = 1'b0;
                    end
                end
                default: pc_next = take ? x_reg : pc_reg + 8'd2;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg    <= LIMIT_RESET;
            pc_reg     <= 8'd0;
            sp_reg     <= SP_RESET;
            flags_reg  <= 4'd0;
            run_reg    <= 1'b0;
            rdbyte_reg <= 8'd0;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= 32'd0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                lim_reg <= cfg_data;
            end
            pc_reg    <= pc_next;
            sp_reg    <= sp_next;
            flags_reg <= flags_next;
            run_reg   <= run_next;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= rf_next[i];
            end
            if (cmd.latch)
            begin
                rdbyte_reg <= 8'd0;
            end
            else if (cmd.cap == CAP_READ)
            begin
                rdbyte_reg <= mem_rdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            haddr_reg <= address;
            hdata_reg <= data;
        end
        case (cmd.cap)
            CAP_OP:   op_reg   <= mem_rdata;
            CAP_X:    x_reg    <= mem_rdata;
            // A fetch past the top of memory reads as zero instead of wrapping.
            CAP_Y:    y_reg    <= (pcw + 10'd2 < 10'(MEM_BYTES)) ? mem_rdata : 8'd0;
            CAP_WORD: word_reg <= {mem_rdata, word_reg[31:8]};
            default:  ;
        endcase
    end

    assign running   = run_reg;
    assign pc        = pc_reg;
    assign sp        = sp_reg;
    assign flags     = flags_reg;
    assign read_data = rdbyte_reg;
    assign reg0      = rf_reg[0];
    assign reg1      = rf_reg[1];
    assign reg2      = rf_reg[2];
    assign reg3      = rf_reg[3];

endmodule

`default_nettype wire

// ===== src/byte_coded_cpu_core.sv =====
// ============================================================================
// byte_coded_cpu_core
// Small byte coded CPU with a 256 byte memory and a host command port.
// ============================================================================
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  command  | start / busy            | action, address, data
//  result   | done (one cycle strobe) | running, pc, sp, flags, read_data,
//           |                         | reg0..reg3
//  config   | cfg_valid / cfg_ready   | cfg_data (data limit)
//
// A start goes straight to the result; a memory write passes through a write
// state and a memory read through an address and a capture state. An execute
// only checks when halted or when the PC is at or above the data limit; else
// it fetches and decodes, then a store, push or call writes a word and a move,
// load, pop or return reads one, before the commit. Word transfers follow the
// single byte memory port: one byte per cycle plus the registered read.
// Reset clears the registers, PC, flags and run flag; memory is not cleared.
// The result strobe cannot be stalled; busy stays high until it is shown.
`default_nettype none

module byte_coded_cpu_core import bcc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  address,
    input  wire logic [7:0]  data,
    output logic             done,
    output logic             running,
    output logic [7:0]       pc,
    output logic [7:0]       sp,
    output logic [3:0]       flags,
    output logic [7:0]       read_data,
    output logic [31:0]      reg0,
    output logic [31:0]      reg1,
    output logic [31:0]      reg2,
    output logic [31:0]      reg3,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    bcc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .action(action),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    bcc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .address  (address),
        .data     (data),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .sts      (sts),
        .running  (running),
        .pc       (pc),
        .sp       (sp),
        .flags    (flags),
        .read_data(read_data),
        .reg0     (reg0),
        .reg1     (reg1),
        .reg2     (reg2),
        .reg3     (reg3)
    );

endmodule

`default_nettype wire

// ===== src/bcc_checker.sv =====
// ============================================================================
// bcc_checker
// Port level checks of the command and result handshake.
// ============================================================================
`default_nettype none

module bcc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    // The result strobe lasts exactly one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // The core is busy while it shows a result.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done shown while not busy");

    // An accepted item makes the core busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but core not busy");

    // No result appears without an accepted item.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !done)
        else $error("result without an item");

endmodule

bind byte_coded_cpu_core bcc_checker u_bcc_checker (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .done (done)
);

`default_nettype wire
